// File: src/bklp_pkg.sv
// Shared types, codes and constants for the byte-keyed linear-probe table.
`timescale 1ns / 1ps
`default_nettype none
package bklp_pkg;

  localparam int DEPTH_DEF = 256;

  localparam logic [15:0] MULT_RST = 16'd40503;
  localparam logic [8:0]  SIZE_RST = 9'd256;

  localparam logic FN_LOOKUP = 1'b0;
  localparam logic FN_INSERT = 1'b1;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic REG_MULT = 1'b0;
  localparam logic REG_SIZE = 1'b1;

  typedef struct packed {
    logic        func;
    logic [7:0]  key;
    logic [63:0] entry;
  } in_req_t;

  typedef struct packed {
    logic [63:0] found_word;
    logic [1:0]  status;
  } out_rsp_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic hash1;
    logic hash2;
    logic probe;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic hit;
    logic exhausted;
  } dp_sts_t;

endpackage
`default_nettype wire

// File: src/bklp_regs.sv
// APB configuration registers: hash multiplier and table size.
`timescale 1ns / 1ps
`default_nettype none
module bklp_regs import bklp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic [15:0]      mult,
  output logic [8:0]       tsize
);

  logic [15:0] mult_r;
  logic [8:0]  tsize_r;
  logic        wr_en;
  logic        idx;

  assign pready = 1'b1;
  assign idx    = paddr[2];
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mult_r  <= MULT_RST;
      tsize_r <= SIZE_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_MULT: mult_r  <= pwdata[15:0];
        REG_SIZE: tsize_r <= pwdata[8:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MULT: prdata = {16'd0, mult_r};
      REG_SIZE: prdata = {23'd0, tsize_r};
    endcase
  end

  assign mult  = mult_r;
  assign tsize = tsize_r;

endmodule
`default_nettype wire

// File: src/bklp_dp.sv
// Datapath: hash, probe pointer, slot memory with clearing pass, result registers.
`timescale 1ns / 1ps
`default_nettype none
module bklp_dp import bklp_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire ctrl_cmd_t  cmd,
  output dp_sts_t         sts,
  input  wire in_req_t    in_req,
  input  wire logic [15:0] mult,
  input  wire logic [8:0]  tsize,
  output out_rsp_t        out_rsp
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SMAX = (DEPTH < 511) ? DEPTH : 511;
  localparam int CW   = $clog2(SMAX + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [63:0]    mem [DEPTH];

  logic [AW-1:0]  clr_ptr_r;
  logic           dv_r;
  logic           func_r;
  logic [7:0]     key_r;
  logic [63:0]    entry_r;
  logic [15:0]    frac_r;
  logic [CW-1:0]  size_r;
  logic [AW-1:0]  ptr_r;
  logic [CW-1:0]  issued_r;
  logic [63:0]    rd_r;
  logic [AW-1:0]  rd_addr_r;
  logic [63:0]    res_word_r;
  logic [1:0]     res_status_r;
  out_rsp_t       out_r;

  logic [CW-1:0]  size_c;
  logic [23:0]    fprod;
  logic [CW+15:0] hprod;
  logic [AW:0]    ptr_inc;
  logic [AW-1:0]  ptr_nxt;
  logic           issue;
  logic           match;
  logic           hit;
  logic           exhausted;
  logic           wr_en;

  always_comb begin
    if (tsize == 9'd0) begin
      size_c = CW'(1);
    end else if (int'(tsize) > DEPTH) begin
      size_c = CW'(DEPTH);
    end else begin
      size_c = CW'(tsize);
    end
  end

  assign fprod   = key_r * mult;
  assign hprod   = size_r * frac_r;
  assign ptr_inc = {1'b0, ptr_r} + 1'b1;
  assign ptr_nxt = (ptr_inc >= (AW+1)'(size_r)) ? '0 : ptr_inc[AW-1:0];
  assign issue   = (issued_r != size_r);
  assign match   = (func_r == FN_INSERT) ? (rd_r == 64'd0)
                                         : ((rd_r != 64'd0) && (rd_r[7:0] == key_r));
  assign hit       = dv_r && match;
  assign exhausted = !dv_r && !issue;
  assign wr_en     = cmd.probe && hit && (func_r == FN_INSERT);

  assign sts.clear_done = (clr_ptr_r == LAST);
  assign sts.hit        = hit;
  assign sts.exhausted  = exhausted;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_ptr_r <= '0;
      dv_r      <= 1'b0;
    end else begin
      if (cmd.clear) begin
        clr_ptr_r <= clr_ptr_r + 1'b1;
      end
      if (cmd.hash2) begin
        dv_r <= 1'b0;
      end else if (cmd.probe) begin
        dv_r <= issue;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r  <= in_req.func;
      key_r   <= (in_req.func == FN_INSERT) ? in_req.entry[7:0] : in_req.key;
      entry_r <= in_req.entry;
    end
    if (cmd.hash1) begin
      frac_r <= fprod[15:0];
      size_r <= size_c;
    end
    if (cmd.hash2) begin
      ptr_r    <= AW'(hprod[CW+15:16]);
      issued_r <= '0;
    end
    if (cmd.probe && issue) begin
      ptr_r     <= ptr_nxt;
      issued_r  <= issued_r + 1'b1;
      rd_addr_r <= ptr_r;
    end
    if (cmd.probe && (hit || exhausted)) begin
      res_word_r   <= (hit && (func_r == FN_LOOKUP)) ? rd_r : 64'd0;
      res_status_r <= hit ? ST_OK : ((func_r == FN_INSERT) ? ST_FULL : ST_MISS);
    end
    if (cmd.out_load) begin
      out_r.found_word <= res_word_r;
      out_r.status     <= res_status_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      mem[clr_ptr_r] <= 64'd0;
    end else if (wr_en) begin
      mem[rd_addr_r] <= entry_r;
    end
    if (cmd.probe && issue) begin
      rd_r <= mem[ptr_r];
    end
  end

  assign out_rsp = out_r;

endmodule
`default_nettype wire

// File: src/bklp_ctrl.sv
// Controller: clearing pass, hash steps, probe loop and output register handoff.
`timescale 1ns / 1ps
`default_nettype none
module bklp_ctrl import bklp_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  wire logic    out_ready,
  output ctrl_cmd_t    cmd,
  input  wire dp_sts_t sts
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HASH1 = 3'd2;
  localparam logic [2:0] S_HASH2 = 3'd3;
  localparam logic [2:0] S_PROBE = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_HASH1;
        end
      end
      S_HASH1: begin
        cmd.hash1 = 1'b1;
        state_nxt = S_HASH2;
      end
      S_HASH2: begin
        cmd.hash2 = 1'b1;
        state_nxt = S_PROBE;
      end
      S_PROBE: begin
        cmd.probe = 1'b1;
        if (sts.hit || sts.exhausted) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

// File: src/byte_keyed_linear_probe_table_unit.sv
// Top level of the byte-keyed linear-probe table unit.
// Usage:
//   in channel (in_valid/in_ready/in_req) takes one request: lookup by key or
//   insert of a 64-bit word keyed by its low byte. out channel
//   (out_valid/out_ready/out_rsp) returns exactly one response per request.
//   APB port (psel..pready) holds hash_multiplier at 0x0 and table_size at 0x4.
// Timing:
//   Hashing runs in the HASH1 and HASH2 steps, one multiplier each. The probe
//   loop reads one slot per cycle from the slot memory through a registered
//   read; writes use a separate port. in_ready rises together with out_valid,
//   so a new request is accepted only after the last one is loaded into the
//   output register.
// Reset:
//   A clearing pass zeroes the slot memory, one slot per cycle; in_ready
//   stays low until it ends. Registers return to their reset values.
// Stall:
//   A response waits in the output register; the next request is accepted
//   meanwhile and its response is held in the datapath until the register frees.
`timescale 1ns / 1ps
`default_nettype none
module byte_keyed_linear_probe_table_unit import bklp_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_req_t     in_req,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_rsp_t         out_rsp,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  ctrl_cmd_t   cmd;
  dp_sts_t     sts;
  logic [15:0] mult;
  logic [8:0]  tsize;

  bklp_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .mult    (mult),
    .tsize   (tsize)
  );

  bklp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  bklp_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .sts     (sts),
    .in_req  (in_req),
    .mult    (mult),
    .tsize   (tsize),
    .out_rsp (out_rsp)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready high right after accept");

  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.clear, cmd.load, cmd.hash1, cmd.hash2, cmd.probe, cmd.out_load}))
    else $error("more than one datapath command");

  a_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_rsp.status != ST_OK)) |-> (out_rsp.found_word == 64'd0))
    else $error("nonzero word with miss or full status");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_rsp.status == ST_OK) || (out_rsp.status == ST_MISS) ||
                   (out_rsp.status == ST_FULL)))
    else $error("invalid status code");

endmodule
`default_nettype wire

// File: dv/bklp_probe_checker.sv
// Checker for the probe table unit: shadows the slot store and compares responses.
`timescale 1ns / 1ps
module bklp_probe_checker import bklp_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire in_req_t     in_req,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire out_rsp_t    out_rsp,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic        pready,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output int               fail_count,
  output int               pending
);

  logic [15:0] mult_q;
  logic [8:0]  size_q;
  logic [63:0] slot_shadow [DEPTH];
  out_rsp_t    expected_rsp_q [$];

  // Walks the shadow store in probe order; an insert updates it.
  function automatic out_rsp_t probe_table(input in_req_t r);
    out_rsp_t    rsp;
    int unsigned sz;
    int unsigned k;
    int unsigned home;
    int unsigned slot;
    sz = (size_q == 9'd0) ? 32'd1 :
         ((32'(size_q) > DEPTH) ? 32'(DEPTH) : 32'(size_q));
    k = (r.func == FN_INSERT) ? 32'(r.entry[7:0]) : 32'(r.key);
    home = (sz * ((k * 32'(mult_q)) & 32'hFFFF)) >> 16;
    rsp.found_word = '0;
    rsp.status = (r.func == FN_INSERT) ? ST_FULL : ST_MISS;
    for (int i = 0; i < sz; i++) begin
      slot = home + i;
      if (slot >= sz) slot -= sz;
      if (r.func == FN_INSERT) begin
        if (slot_shadow[slot] == '0) begin
          slot_shadow[slot] = r.entry;
          rsp.status = ST_OK;
          break;
        end
      end else if (slot_shadow[slot] != '0 && slot_shadow[slot][7:0] == r.key) begin
        rsp.found_word = slot_shadow[slot];
        rsp.status = ST_OK;
        break;
      end
    end
    return rsp;
  endfunction

  always @(posedge clk) begin
    out_rsp_t exp_rsp;
    if (!rst_n) begin
      mult_q = MULT_RST;
      size_q = SIZE_RST;
      for (int i = 0; i < DEPTH; i++) slot_shadow[i] = '0;
      expected_rsp_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_MULT) mult_q = pwdata[15:0];
        else if (paddr[2] == REG_SIZE) size_q = pwdata[8:0];
      end
      if (out_valid && out_ready) begin
        if (expected_rsp_q.size() == 0) begin
          $display("%0t: response with none expected: found_word=%h status=%0d",
                   $time, out_rsp.found_word, out_rsp.status);
          fail_count++;
        end else begin
          exp_rsp = expected_rsp_q.pop_front();
          if (out_rsp.found_word !== exp_rsp.found_word) begin
            $display("%0t: found_word expected %h actual %h",
                     $time, exp_rsp.found_word, out_rsp.found_word);
            fail_count++;
          end
          if (out_rsp.status !== exp_rsp.status) begin
            $display("%0t: status expected %0d actual %0d",
                     $time, exp_rsp.status, out_rsp.status);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) expected_rsp_q.push_back(probe_table(in_req));
    end
    pending = expected_rsp_q.size();
  end

endmodule

// File: dv/tb_byte_keyed_linear_probe_table_unit.sv
// Testbench top for the probe table unit: stimulus, handshake pacing and verdict.
`timescale 1ns / 1ps
module tb_byte_keyed_linear_probe_table_unit import bklp_pkg::*;;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_req_t     in_req;
  logic        out_valid;
  logic        out_ready;
  out_rsp_t    out_rsp;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int         fail_count;
  int         pending;
  bit         no_idle;
  logic [7:0] key_pool [8];
  logic [7:0] stored_keys [$];

  always #5 clk = ~clk;

  byte_keyed_linear_probe_table_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_req(in_req),
    .out_valid(out_valid), .out_ready(out_ready), .out_rsp(out_rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  bklp_probe_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_req(in_req),
    .out_valid(out_valid), .out_ready(out_ready), .out_rsp(out_rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

  // response side back-pressure
  initial begin
    int gap;
    out_ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  task automatic send_req(input in_req_t r);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (!in_ready);
    if (r.func == FN_INSERT && r.entry != '0) stored_keys.push_back(r.entry[7:0]);
    @(negedge clk);
  endtask

  task automatic issue(input logic fn, input logic [7:0] k, input logic [63:0] w);
    in_req_t r;
    r.func = fn;
    r.key = k;
    r.entry = w;
    send_req(r);
  endtask

  // hold the request side until every response is back
  task automatic wait_idle();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (pending != 0 && guard < 10000) begin
      @(negedge clk);
      guard++;
    end
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic random_item();
    in_req_t r;
    int      pick;
    r.func = ($urandom_range(0, 99) < 45) ? FN_INSERT : FN_LOOKUP;
    r.key = 8'($urandom);
    r.entry = {$urandom, $urandom};
    pick = $urandom_range(0, 99);
    if (r.func == FN_INSERT) begin
      if (pick < 3) r.entry = '0;
      else if (pick < 5) r.entry = '1;
      else if (pick < 55) r.entry[7:0] = key_pool[$urandom_range(0, 7)];
      else if (pick < 65) r.entry[7:0] = 8'h00;
    end else begin
      if (pick < 60 && stored_keys.size() > 0)
        r.key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
      else if (pick < 80) r.key = key_pool[$urandom_range(0, 7)];
    end
    send_req(r);
  endtask

  task automatic run_phase(input logic [15:0] mult, input logic [8:0] size, input int count,
                           input bit rush);
    wait_idle();
    write_reg(REG_MULT, {16'($urandom), mult});
    write_reg(REG_SIZE, {23'($urandom), size});
    no_idle = rush;
    for (int i = 0; i < 8; i++) key_pool[i] = 8'($urandom);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 49) == 0) wait_idle();
      random_item();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    no_idle = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    do @(negedge clk); while (!in_ready);

    // reset settings: empty table, zero word, key zero, duplicates
    issue(FN_LOOKUP, 8'h00, 64'h0);
    issue(FN_INSERT, 8'hA5, 64'h0);
    issue(FN_LOOKUP, 8'h00, '1);
    issue(FN_INSERT, 8'h00, 64'hFFFF_FFFF_FFFF_FFFF);
    issue(FN_LOOKUP, 8'hFF, 64'h0);
    issue(FN_INSERT, 8'hFF, 64'h0123_4567_89AB_CD00);
    issue(FN_LOOKUP, 8'h00, 64'h0);
    issue(FN_INSERT, 8'hFF, 64'h8000_0000_0000_0042);
    issue(FN_INSERT, 8'h00, 64'h7FFF_FFFF_FFFF_FF42);
    issue(FN_LOOKUP, 8'h42, '1);
    issue(FN_LOOKUP, 8'h13, 64'h0);

    // single slot: full table, hidden words
    wait_idle();
    write_reg(REG_MULT, 32'h0);
    write_reg(REG_SIZE, 32'd1);
    issue(FN_INSERT, 8'h00, 64'h5555_AAAA_5555_AA11);
    issue(FN_LOOKUP, 8'h00, 64'h0);
    issue(FN_LOOKUP, 8'hFF, 64'h0);
    issue(FN_INSERT, 8'h00, 64'h0);

    // size zero behaves as one
    wait_idle();
    write_reg(REG_SIZE, 32'd0);
    issue(FN_LOOKUP, 8'h00, 64'h0);
    issue(FN_INSERT, 8'h00, 64'h0000_0000_0000_0077);

    // size above depth clamps
    wait_idle();
    write_reg(REG_MULT, 32'hFFFF);
    write_reg(REG_SIZE, 32'd511);
    issue(FN_LOOKUP, 8'hFF, 64'h0);
    issue(FN_LOOKUP, 8'h42, 64'h0);
    issue(FN_LOOKUP, 8'h00, 64'h0);
    issue(FN_INSERT, 8'h00, 64'hDEAD_BEEF_0000_0142);
    issue(FN_LOOKUP, 8'h42, 64'h0);

    run_phase(16'h0000, 9'd0, 40, 1'b0);
    run_phase(16'hFFFF, 9'd5, 80, 1'b0);
    run_phase(16'($urandom), 9'd16, 120, 1'b1);
    run_phase(16'h0001, 9'd300, 100, 1'b0);
    run_phase(16'($urandom), 9'd64, 150, 1'b0);
    run_phase(16'd40503, 9'd511, 200, 1'b0);
    run_phase(16'($urandom), 9'd256, 150, 1'b0);
    run_phase(16'($urandom), 9'd3, 60, 1'b0);

    wait_idle();
    repeat (300) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
